/* hdl/lsp_pkg.sv */
// Shared definitions for the line pixel stepper: opcode values, default widths
// and the flag struct passed between the setup logic and the top level.
// No dependencies.
`default_nettype none

package lsp_pkg;

    // Default coordinate width in bits.
    localparam int COORD_WIDTH_DEF = 16;

    // Opcode values carried in the input tuser bit.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Line mode flags produced on a start transfer.
    typedef struct packed {
        logic steep;      // y is the major axis
        logic minor_dir;  // minor coordinate decrements
        logic active;     // more pixels follow
    } lsp_flags_t;

endpackage

`default_nettype wire

/* hdl/lsp_line_setup.sv */
// Start-of-line setup: picks the major axis, orders the endpoints along it and
// derives the spans and the minor direction. Depends on lsp_pkg.
`default_nettype none

module lsp_line_setup #(
    parameter int COORD_WIDTH = lsp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    output logic signed [COORD_WIDTH-1:0]      major_pos,
    output logic signed [COORD_WIDTH-1:0]      minor_pos,
    output logic signed [COORD_WIDTH-1:0]      major_end,
    output logic        [COORD_WIDTH:0]        major_span,
    output logic        [COORD_WIDTH:0]        minor_span,
    output lsp_pkg::lsp_flags_t                flags,
    output logic                               single_point
);

    logic signed [COORD_WIDTH:0]   dx;
    logic signed [COORD_WIDTH:0]   dy;
    logic        [COORD_WIDTH:0]   abs_dx;
    logic        [COORD_WIDTH:0]   abs_dy;
    logic                          steep;
    logic signed [COORD_WIDTH-1:0] a0;
    logic signed [COORD_WIDTH-1:0] b0;
    logic signed [COORD_WIDTH-1:0] a1;
    logic signed [COORD_WIDTH-1:0] b1;
    logic signed [COORD_WIDTH-1:0] lo_a;
    logic signed [COORD_WIDTH-1:0] lo_b;
    logic signed [COORD_WIDTH-1:0] hi_a;
    logic signed [COORD_WIDTH-1:0] hi_b;
    logic signed [COORD_WIDTH:0]   db;
    logic        [COORD_WIDTH:0]   span_a;

    // Spans on both axes, sign-extended by one bit so the differences are exact.
    always_comb
    begin
        dx     = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
        dy     = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
        abs_dx = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
        abs_dy = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
        steep  = abs_dy > abs_dx;
    end

    // Map the endpoints onto major and minor axes, then order by major coordinate.
    always_comb
    begin
        if (steep)
        begin
            a0 = start_y;
            b0 = start_x;
            a1 = end_y;
            b1 = end_x;
        end
        else
        begin
            a0 = start_x;
            b0 = start_y;
            a1 = end_x;
            b1 = end_y;
        end
        if (a1 < a0)
        begin
            lo_a = a1;
            lo_b = b1;
            hi_a = a0;
            hi_b = b0;
        end
        else
        begin
            lo_a = a0;
            lo_b = b0;
            hi_a = a1;
            hi_b = b1;
        end
    end

    // Spans and direction of the ordered line.
    always_comb
    begin
        span_a = $unsigned({hi_a[COORD_WIDTH-1], hi_a} - {lo_a[COORD_WIDTH-1], lo_a});
        db     = {hi_b[COORD_WIDTH-1], hi_b} - {lo_b[COORD_WIDTH-1], lo_b};
    end

    assign major_pos       = lo_a;
    assign minor_pos       = lo_b;
    assign major_end       = hi_a;
    assign major_span      = span_a;
    assign minor_span      = db[COORD_WIDTH] ? $unsigned(-db) : $unsigned(db);
    assign single_point    = (span_a == '0);
    assign flags.steep     = steep;
    assign flags.minor_dir = db[COORD_WIDTH];
    assign flags.active    = (span_a != '0);

endmodule

`default_nettype wire

/* hdl/lsp_pixel_step.sv */
// One step of the integer error rule: advance the major coordinate, accumulate
// twice the minor span and move the minor coordinate at the half-pixel point.
// Depends on lsp_pkg.
`default_nettype none

module lsp_pixel_step #(
    parameter int COORD_WIDTH = lsp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic signed [COORD_WIDTH-1:0] major_pos,
    input  wire logic signed [COORD_WIDTH-1:0] minor_pos,
    input  wire logic signed [COORD_WIDTH-1:0] major_end,
    input  wire logic        [COORD_WIDTH:0]   major_span,
    input  wire logic        [COORD_WIDTH:0]   minor_span,
    input  wire logic signed [COORD_WIDTH+2:0] error_acc,
    input  wire logic                          minor_dir,
    output logic signed [COORD_WIDTH-1:0]      major_pos_next,
    output logic signed [COORD_WIDTH-1:0]      minor_pos_next,
    output logic signed [COORD_WIDTH+2:0]      error_acc_next,
    output logic                               last
);

    logic signed [COORD_WIDTH+2:0] err_sum;
    logic signed [COORD_WIDTH+2:0] threshold;
    logic signed [COORD_WIDTH+2:0] two_major;
    logic                          move_minor;

    // Error accumulation and the minor-axis decision.
    always_comb
    begin
        err_sum    = error_acc + $signed({1'b0, minor_span, 1'b0});
        threshold  = $signed({2'b00, major_span});
        two_major  = $signed({1'b0, major_span, 1'b0});
        move_minor = (err_sum >= threshold);
    end

    // Coordinate updates; the major coordinate never passes the end while active.
    always_comb
    begin
        major_pos_next = major_pos + COORD_WIDTH'(1);
        if (move_minor)
        begin
            minor_pos_next = minor_dir ? (minor_pos - COORD_WIDTH'(1))
                                       : (minor_pos + COORD_WIDTH'(1));
            error_acc_next = err_sum - two_major;
        end
        else
        begin
            minor_pos_next = minor_pos;
            error_acc_next = err_sum;
        end
        last = (major_pos_next >= major_end);
    end

endmodule

`default_nettype wire

/* hdl/line_pixel_stepper_unit.sv */
// Line pixel stepper top level: input register, line state, setup and step
// logic, and the output register. Depends on lsp_pkg, lsp_line_setup, lsp_pixel_step.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata/s_tuser): s_tuser is the opcode.
//   A start transfer (opcode 0) carries both endpoints and yields the first
//   pixel; a step transfer (opcode 1) yields the next pixel of the line, or
//   nothing when no line is active. A start during a line abandons it.
//   Output stream (m_tvalid/m_tready/m_tdata/m_tlast): one pixel per transfer,
//   m_tlast marks the line's final endpoint.
//   Path: each pixel is built from the item in the input register and is
//   loaded into the output register, where it raises m_tvalid; a stall can
//   hold an item in either register.
//   Throughput: one input item per cycle while no held pixel stalls the output;
//   the line state is updated in one pass of setup or step logic from the input
//   register into the state and output registers.
//   Stall: while m_tready is low and a pixel is held, the input register stops
//   and s_tready drops once it is occupied; nothing is lost or repeated.
//   Reset: rst_n clears the line state to idle and empties both registers.
`default_nettype none

module line_pixel_stepper_unit #(
    parameter int COORD_WIDTH = lsp_pkg::COORD_WIDTH_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // From the lowest bit: start_x, start_y, end_x, end_y, zero fill.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Bit 0: opcode.
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // From the lowest bit: pixel_x, pixel_y, zero fill.
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam int W = COORD_WIDTH;

    // Input register.
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                in_op_reg;
    logic signed [W-1:0] in_sx_reg;
    logic signed [W-1:0] in_sy_reg;
    logic signed [W-1:0] in_ex_reg;
    logic signed [W-1:0] in_ey_reg;

    // Line state.
    logic signed [W-1:0] major_pos_reg;
    logic signed [W-1:0] major_pos_next;
    logic signed [W-1:0] minor_pos_reg;
    logic signed [W-1:0] minor_pos_next;
    logic signed [W-1:0] major_end_reg;
    logic signed [W-1:0] major_end_next;
    logic        [W:0]   major_span_reg;
    logic        [W:0]   major_span_next;
    logic        [W:0]   minor_span_reg;
    logic        [W:0]   minor_span_next;
    logic signed [W+2:0] error_acc_reg;
    logic signed [W+2:0] error_acc_next;
    logic                minor_dir_reg;
    logic                minor_dir_next;
    logic                steep_mode_reg;
    logic                steep_mode_next;
    logic                line_active_reg;
    logic                line_active_next;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic signed [W-1:0] out_x_reg;
    logic signed [W-1:0] out_y_reg;
    logic                out_last_reg;

    // Setup and step results.
    logic signed [W-1:0] su_major_pos;
    logic signed [W-1:0] su_minor_pos;
    logic signed [W-1:0] su_major_end;
    logic        [W:0]   su_major_span;
    logic        [W:0]   su_minor_span;
    lsp_pkg::lsp_flags_t su_flags;
    logic                su_single;
    logic signed [W-1:0] st_major_pos;
    logic signed [W-1:0] st_minor_pos;
    logic signed [W+2:0] st_error_acc;
    logic                st_last;

    logic                advance;
    logic                is_start;
    logic                out_load;
    logic                pix_last;
    logic signed [W-1:0] pix_major;
    logic signed [W-1:0] pix_minor;
    logic                pix_steep;

    // Handshake: the input register moves on whenever the output slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign is_start = (in_op_reg == lsp_pkg::OP_START);
    assign out_load = advance && (is_start || line_active_reg);

    lsp_line_setup #(
        .COORD_WIDTH(W)
    ) u_setup (
        .start_x      (in_sx_reg),
        .start_y      (in_sy_reg),
        .end_x        (in_ex_reg),
        .end_y        (in_ey_reg),
        .major_pos    (su_major_pos),
        .minor_pos    (su_minor_pos),
        .major_end    (su_major_end),
        .major_span   (su_major_span),
        .minor_span   (su_minor_span),
        .flags        (su_flags),
        .single_point (su_single)
    );

    lsp_pixel_step #(
        .COORD_WIDTH(W)
    ) u_step (
        .major_pos      (major_pos_reg),
        .minor_pos      (minor_pos_reg),
        .major_end      (major_end_reg),
        .major_span     (major_span_reg),
        .minor_span     (minor_span_reg),
        .error_acc      (error_acc_reg),
        .minor_dir      (minor_dir_reg),
        .major_pos_next (st_major_pos),
        .minor_pos_next (st_minor_pos),
        .error_acc_next (st_error_acc),
        .last           (st_last)
    );

    // Next line state and the pixel to emit.
    always_comb
    begin
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_end_next   = major_end_reg;
        major_span_next  = major_span_reg;
        minor_span_next  = minor_span_reg;
        error_acc_next   = error_acc_reg;
        minor_dir_next   = minor_dir_reg;
        steep_mode_next  = steep_mode_reg;
        line_active_next = line_active_reg;
        if (is_start)
        begin
            pix_major = su_major_pos;
            pix_minor = su_minor_pos;
            pix_steep = su_flags.steep;
            pix_last  = su_single;
        end
        else
        begin
            pix_major = st_major_pos;
            pix_minor = st_minor_pos;
            pix_steep = steep_mode_reg;
            pix_last  = st_last;
        end
        if (advance && is_start)
        begin
            major_pos_next   = su_major_pos;
            minor_pos_next   = su_minor_pos;
            major_end_next   = su_major_end;
            major_span_next  = su_major_span;
            minor_span_next  = su_minor_span;
            error_acc_next   = '0;
            minor_dir_next   = su_flags.minor_dir;
            steep_mode_next  = su_flags.steep;
            line_active_next = su_flags.active;
        end
        else if (advance && line_active_reg)
        begin
            major_pos_next   = st_major_pos;
            minor_pos_next   = st_minor_pos;
            error_acc_next   = st_error_acc;
            line_active_next = !st_last;
        end
    end

    // Valid flags of the two registers.
    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_end_reg   <= '0;
            major_span_reg  <= '0;
            minor_span_reg  <= '0;
            error_acc_reg   <= '0;
            minor_dir_reg   <= 1'b0;
            steep_mode_reg  <= 1'b0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_end_reg   <= major_end_next;
            major_span_reg  <= major_span_next;
            minor_span_reg  <= minor_span_next;
            error_acc_reg   <= error_acc_next;
            minor_dir_reg   <= minor_dir_next;
            steep_mode_reg  <= steep_mode_next;
            line_active_reg <= line_active_next;
        end
    end

    // Payload registers, loaded on their transfers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg <= s_tuser;
            in_sx_reg <= s_tdata[W-1:0];
            in_sy_reg <= s_tdata[2*W-1:W];
            in_ex_reg <= s_tdata[3*W-1:2*W];
            in_ey_reg <= s_tdata[4*W-1:3*W];
        end
        if (out_load)
        begin
            out_x_reg    <= pix_steep ? pix_minor : pix_major;
            out_y_reg    <= pix_steep ? pix_major : pix_minor;
            out_last_reg <= pix_last;
        end
    end

    // Output ports.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_W'({out_y_reg, out_x_reg});

    // While a line runs, the major coordinate is short of the end.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (major_pos_reg < major_end_reg))
        else $error("active line has reached its major end");

    // While a line runs, the error stays within one major span of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> ((error_acc_reg >= -$signed({2'b00, major_span_reg}))
                          && (error_acc_reg < $signed({2'b00, major_span_reg}))))
        else $error("error accumulator out of range");

    // The minor span never exceeds the major span of an active line.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (minor_span_reg <= major_span_reg))
        else $error("minor span exceeds major span");

    // Emitting the final pixel leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pix_last) |=> !line_active_reg)
        else $error("line still active after its last pixel");

endmodule

`default_nettype wire
